### rtl/core/cuwf_pkg.sv
// ----------------------------------------------------------------------------
// cuwf_pkg
// shared types, constants and the scaling coefficient rom of the
// circular undecimated wavelet filter
// ----------------------------------------------------------------------------
`default_nettype none

package cuwf_pkg;

   localparam int MAX_TAPS_DEF    = 10;
   localparam int ROW_MAX_DEF     = 4096;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int FIELD_W    = 16;
   localparam int RES_W      = 18;
   localparam int POS_W      = 12;
   localparam int COEF_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVELET   = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FOLD,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic clear;
      logic tap;
      logic fold;
      logic dir;
   } mac_ctrl_type;

   // q1.15 scaling coefficients, one row per wavelet (db2 .. db5)
   localparam logic signed [COEF_W-1:0] SCALE_ROM [4][10] = '{
      '{16'sd15826, 16'sd27411, 16'sd7345, -16'sd4240, 16'sd0, 16'sd0,
        16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd10901, 16'sd26440, 16'sd15069, -16'sd4424, -16'sd2800, 16'sd1154,
        16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd7549, 16'sd23424, 16'sd20673, -16'sd917, -16'sd6129, 16'sd1011,
        16'sd1078, -16'sd347, 16'sd0, 16'sd0},
      '{16'sd5246, 16'sd19786, 16'sd23734, 16'sd4536, -16'sd7940, -16'sd1057,
        16'sd2542, -16'sd205, -16'sd412, 16'sd109}
   };

   function automatic logic signed [COEF_W-1:0] coef_at(input logic [1:0] row,
                                                        input logic [3:0] idx);
      logic signed [COEF_W-1:0] v;
      v = '0;
      if (idx < 4'd10) begin
         v = SCALE_ROM[row][idx];
      end
      return v;
   endfunction

endpackage

`default_nettype wire

### rtl/core/cuwf_mem.sv
// ----------------------------------------------------------------------------
// cuwf_mem
// sample pair memory, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module cuwf_mem #(
   parameter int DEPTH = 10,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/cuwf_mac.sv
// ----------------------------------------------------------------------------
// cuwf_mac
// two multipliers with product registers, two accumulators, rounding and
// saturation to the result width
// ----------------------------------------------------------------------------
`default_nettype none

module cuwf_mac #(
   parameter int SAMPLE_BITS = cuwf_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire cuwf_pkg::mac_ctrl_type                  ctrl,
   input  wire logic signed [SAMPLE_BITS-1:0]           data_a,
   input  wire logic signed [SAMPLE_BITS-1:0]           data_b,
   input  wire logic signed [cuwf_pkg::COEF_W-1:0]      coef_s,
   input  wire logic signed [cuwf_pkg::COEF_W-1:0]      coef_g,
   output logic                                         busy,
   output logic signed [cuwf_pkg::RES_W-1:0]            result_lo,
   output logic signed [cuwf_pkg::RES_W-1:0]            result_hi
);

   localparam int PROD_W = SAMPLE_BITS + cuwf_pkg::COEF_W;
   localparam int ACC_W  = PROD_W + 6;
   localparam int RES_W  = cuwf_pkg::RES_W;

   localparam logic signed [ACC_W:0] HALF_Q15 = (ACC_W+1)'(16384);
   localparam logic signed [ACC_W:0] HALF_Q16 = (ACC_W+1)'(32768);
   localparam logic signed [ACC_W:0] SAT_MAX  = (ACC_W+1)'(131071);
   localparam logic signed [ACC_W:0] SAT_MIN  = -(ACC_W+1)'(131072);

   logic signed [PROD_W-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic                     v2_ff, v2_in;
   logic signed [ACC_W-1:0]  acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic signed [SAMPLE_BITS-1:0] mul_b;
   logic signed [ACC_W:0]    r1, r2, q1, q2;

   assign mul_b = ctrl.dir ? data_b : data_a;
   assign p1_in = data_a * coef_s;
   assign p2_in = mul_b * coef_g;
   assign v2_in = ctrl.tap;

   always_comb begin
      acc1_in = acc1_ff;
      acc2_in = acc2_ff;
      if (ctrl.clear) begin
         acc1_in = '0;
         acc2_in = '0;
      end else if (ctrl.fold) begin
         acc1_in = acc1_ff + acc2_ff;
      end else if (v2_ff) begin
         acc1_in = acc1_ff + ACC_W'(p1_ff);
         acc2_in = acc2_ff + ACC_W'(p2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      acc1_ff <= acc1_in;
      acc2_ff <= acc2_in;
   end

   // round half up, then clamp
   always_comb begin
      r1 = (ACC_W+1)'(acc1_ff) + (ctrl.dir ? HALF_Q16 : HALF_Q15);
      r2 = (ACC_W+1)'(acc2_ff) + HALF_Q15;
      q1 = ctrl.dir ? (r1 >>> 16) : (r1 >>> 15);
      q2 = r2 >>> 15;
      if (q1 > SAT_MAX) begin
         result_lo = RES_W'(SAT_MAX);
      end else if (q1 < SAT_MIN) begin
         result_lo = RES_W'(SAT_MIN);
      end else begin
         result_lo = RES_W'(q1);
      end
      if (ctrl.dir) begin
         result_hi = '0;
      end else if (q2 > SAT_MAX) begin
         result_hi = RES_W'(SAT_MAX);
      end else if (q2 < SAT_MIN) begin
         result_hi = RES_W'(SAT_MIN);
      end else begin
         result_hi = RES_W'(q2);
      end
   end

   assign busy = v2_ff;

endmodule

`default_nettype wire

### rtl/core/circular_undecimated_wavelet_filter_top.sv
// input words are taken only in idle, once every result of the previous word
// has been loaded into the output register; each result takes t taps (t = 4..10)
// the tap loop is bound by the single tap read port of the sample memories, one tap a cycle
// reset: synchronous, active high; clears control state, registers to defaults
// sample memories hold no reset value, every tap read hits a word of the current row
`default_nettype none

// ----------------------------------------------------------------------------
// circular_undecimated_wavelet_filter_top
// one level redundant daubechies wavelet over a circular row: decompose into
// low and high bands or reconstruct from them, with wrap flush at row end
// ----------------------------------------------------------------------------
module circular_undecimated_wavelet_filter_top #(
   parameter int MAX_TAPS    = cuwf_pkg::MAX_TAPS_DEF,
   parameter int ROW_MAX     = cuwf_pkg::ROW_MAX_DEF,
   parameter int SAMPLE_BITS = cuwf_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input words
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [cuwf_pkg::FIELD_W-1:0] req_sample_a,
   input  wire logic signed [cuwf_pkg::FIELD_W-1:0] req_sample_b,
   input  wire logic                                req_row_end,
   // result words
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [cuwf_pkg::RES_W-1:0]        rsp_result_low,
   output logic signed [cuwf_pkg::RES_W-1:0]        rsp_result_high,
   output logic [cuwf_pkg::POS_W-1:0]               rsp_position,
   output logic                                     rsp_final_result,
   output logic                                     rsp_short_row,
   // configuration
   input  wire logic                                csr_we,
   input  wire logic [cuwf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cuwf_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int CW     = $clog2(ROW_MAX);          // sample count
   localparam int LW     = CW + 1;                   // row length
   localparam int TW     = $clog2(MAX_TAPS + 1);     // tap index / count
   localparam int WA_W   = $clog2(MAX_TAPS);         // window address
   localparam int HA_W   = $clog2(MAX_TAPS - 1);     // head address
   localparam int EXT_W  = (SAMPLE_BITS > cuwf_pkg::FIELD_W) ? SAMPLE_BITS
                                                             : cuwf_pkg::FIELD_W;
   localparam int MAXROW = (MAX_TAPS - 4) / 2;       // longest wavelet that fits
   localparam logic [CW-1:0]   CNT_LAST = CW'(ROW_MAX - 1);
   localparam logic [WA_W-1:0] WA_LAST  = WA_W'(MAX_TAPS - 1);

   cuwf_pkg::state_type state_ff, state_in;

   // configuration registers
   logic       dir_ff, dir_in;
   logic [1:0] sel_ff, sel_in;

   // row and sequencer state
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [WA_W-1:0] wp_ff, wp_in;
   logic [LW-1:0]   len_ff, len_in;
   logic [TW-1:0]   t_ff, t_in;
   logic [1:0]      row_ff, row_in;
   logic            last_ff, last_in;
   logic            short_ff, short_in;
   logic [TW-1:0]   nout_ff, nout_in;
   logic [TW-1:0]   o_ff, o_in;
   logic [LW-1:0]   pos_ff, pos_in;
   logic [TW-1:0]   tap_ff, tap_in;

   // tap read stage
   logic                              s1_valid_ff, s1_valid_in;
   logic                              s1_win_ff, s1_win_in;
   logic signed [cuwf_pkg::COEF_W-1:0] s1_s_ff, s1_s_in, s1_g_ff, s1_g_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [cuwf_pkg::RES_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [cuwf_pkg::POS_W-1:0]        rpos_ff, rpos_in;
   logic                              fin_ff, fin_in;
   logic                              rshort_ff, rshort_in;

   logic accept, load, last_out;
   logic [CW-1:0]   n_cur;
   logic [LW-1:0]   len_new;
   logic            last_new;
   logic [1:0]      row_new;
   logic [TW-1:0]   t_new;

   // tap address generation
   logic [LW:0]     idx_wide;
   logic [LW-1:0]   idx, lag;
   logic            use_win;
   logic [WA_W:0]   wa_wide;
   logic [WA_W-1:0] win_raddr;
   logic [HA_W-1:0] head_raddr;

   // sample memories
   logic [SAMPLE_BITS-1:0]   samp_a, samp_b;
   logic [EXT_W-1:0]         ext_a, ext_b;
   logic [2*SAMPLE_BITS-1:0] wr_pair, win_rd, head_rd, tap_pair;
   logic                     head_we;

   cuwf_pkg::mac_ctrl_type mac_ctrl;
   logic mac_busy;
   logic signed [cuwf_pkg::RES_W-1:0] mac_lo, mac_hi;

   assign accept   = req_valid && req_ready;
   assign load     = (state_ff == cuwf_pkg::ST_PUSH) && (!rsp_valid_ff || rsp_ready);
   assign last_out = (o_ff == nout_ff - TW'(1));
   assign req_ready = (state_ff == cuwf_pkg::ST_IDLE);

   // word parameters seen at accept
   assign n_cur    = cnt_ff;
   assign len_new  = LW'(cnt_ff) + LW'(1);
   assign last_new = req_row_end || (cnt_ff == CNT_LAST);
   assign row_new  = (sel_ff > 2'(MAXROW)) ? 2'(MAXROW) : sel_ff;
   assign t_new    = TW'(4) + TW'({row_new, 1'b0});

   // sample fields as sample-width two's complement
   assign ext_a   = EXT_W'($unsigned(req_sample_a));
   assign ext_b   = EXT_W'($unsigned(req_sample_b));
   assign samp_a  = ext_a[SAMPLE_BITS-1:0];
   assign samp_b  = ext_b[SAMPLE_BITS-1:0];
   assign wr_pair = {samp_b, samp_a};
   assign head_we = accept && (cnt_ff < CW'(MAX_TAPS - 1));

   // row index of the current tap, wrapped around the row
   always_comb begin
      if (!dir_ff) begin
         idx_wide = (LW+1)'(pos_ff) + (LW+1)'(tap_ff);
         if (idx_wide >= (LW+1)'(len_ff)) begin
            idx_wide = idx_wide - (LW+1)'(len_ff);
         end
      end else begin
         if (pos_ff >= LW'(tap_ff)) begin
            idx_wide = (LW+1)'(pos_ff) - (LW+1)'(tap_ff);
         end else begin
            idx_wide = (LW+1)'(pos_ff) + (LW+1)'(len_ff) - (LW+1)'(tap_ff);
         end
      end
      idx = idx_wide[LW-1:0];
      lag = len_ff - LW'(1) - idx;
   end

   // recent samples come from the circular window, early ones from the head store
   assign use_win    = (lag < LW'(MAX_TAPS));
   assign wa_wide    = (WA_W+1)'(wp_ff) + (WA_W+1)'(MAX_TAPS) - (WA_W+1)'(lag[WA_W-1:0]);
   assign win_raddr  = (wa_wide >= (WA_W+1)'(MAX_TAPS))
                       ? WA_W'(wa_wide - (WA_W+1)'(MAX_TAPS)) : wa_wide[WA_W-1:0];
   assign head_raddr = idx[HA_W-1:0];

   cuwf_mem #(
      .DEPTH (MAX_TAPS),
      .WIDTH (2*SAMPLE_BITS)
   ) u_win_mem (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_in),
      .wr_data (wr_pair),
      .rd_addr (win_raddr),
      .rd_data (win_rd)
   );

   cuwf_mem #(
      .DEPTH (MAX_TAPS - 1),
      .WIDTH (2*SAMPLE_BITS)
   ) u_head_mem (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (cnt_ff[HA_W-1:0]),
      .wr_data (wr_pair),
      .rd_addr (head_raddr),
      .rd_data (head_rd)
   );

   assign tap_pair = s1_win_ff ? win_rd : head_rd;

   cuwf_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .data_a    (tap_pair[SAMPLE_BITS-1:0]),
      .data_b    (tap_pair[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .coef_s    (s1_s_ff),
      .coef_g    (s1_g_ff),
      .busy      (mac_busy),
      .result_lo (mac_lo),
      .result_hi (mac_hi)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cuwf_pkg::ST_IDLE: begin
            if (accept) begin
               if (len_new < LW'(t_new)) begin
                  state_in = last_new ? cuwf_pkg::ST_PUSH : cuwf_pkg::ST_IDLE;
               end else begin
                  state_in = cuwf_pkg::ST_RUN;
               end
            end
         end
         cuwf_pkg::ST_RUN: begin
            if (tap_ff == t_ff - TW'(1)) begin
               state_in = cuwf_pkg::ST_DRAIN;
            end
         end
         cuwf_pkg::ST_DRAIN: begin
            if (!s1_valid_ff && !mac_busy) begin
               state_in = dir_ff ? cuwf_pkg::ST_FOLD : cuwf_pkg::ST_PUSH;
            end
         end
         cuwf_pkg::ST_FOLD: begin
            state_in = cuwf_pkg::ST_PUSH;
         end
         cuwf_pkg::ST_PUSH: begin
            if (load) begin
               state_in = (short_ff || last_out) ? cuwf_pkg::ST_IDLE : cuwf_pkg::ST_RUN;
            end
         end
         default: state_in = cuwf_pkg::ST_IDLE;
      endcase
   end

   // sequencer and datapath controls
   always_comb begin
      dir_in   = dir_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      wp_in    = wp_ff;
      len_in   = len_ff;
      t_in     = t_ff;
      row_in   = row_ff;
      last_in  = last_ff;
      short_in = short_ff;
      nout_in  = nout_ff;
      o_in     = o_ff;
      pos_in   = pos_ff;
      tap_in   = tap_ff;

      mac_ctrl = '{clear: 1'b0, tap: s1_valid_ff, fold: 1'b0, dir: dir_ff};

      s1_valid_in = (state_ff == cuwf_pkg::ST_RUN);
      s1_win_in   = use_win;
      s1_s_in     = cuwf_pkg::coef_at(row_ff, 4'(tap_ff));
      s1_g_in     = cuwf_pkg::coef_at(row_ff, 4'(t_ff - TW'(1) - tap_ff));
      if (tap_ff[0]) begin
         s1_g_in = -s1_g_in;
      end

      // a write to the direction or wavelet register abandons the row in progress
      if (csr_we) begin
         unique case (csr_index)
            cuwf_pkg::CSR_DIRECTION: begin
               dir_in = csr_data[0];
               cnt_in = '0;
            end
            cuwf_pkg::CSR_WAVELET: begin
               sel_in = csr_data[1:0];
               cnt_in = '0;
            end
            default: ;
         endcase
      end

      if (accept) begin
         wp_in    = (wp_ff == WA_LAST) ? '0 : wp_ff + WA_W'(1);
         cnt_in   = last_new ? '0 : CW'(len_new);
         len_in   = len_new;
         t_in     = t_new;
         row_in   = row_new;
         last_in  = last_new;
         short_in = (len_new < LW'(t_new));
         nout_in  = last_new ? t_new : TW'(1);
         o_in     = '0;
         tap_in   = '0;
         pos_in   = dir_ff ? LW'(n_cur) : len_new - LW'(t_new);
         mac_ctrl.clear = 1'b1;
      end

      if (state_ff == cuwf_pkg::ST_RUN) begin
         tap_in = tap_ff + TW'(1);
      end

      if (state_ff == cuwf_pkg::ST_FOLD) begin
         mac_ctrl.fold = 1'b1;
      end

      if (load && !short_ff && !last_out) begin
         o_in   = o_ff + TW'(1);
         tap_in = '0;
         pos_in = (dir_ff && (o_ff == '0)) ? '0 : pos_ff + LW'(1);
         mac_ctrl.clear = 1'b1;
      end
   end

   // output register: holds a finished word while the sequencer goes on
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rpos_in      = rpos_ff;
      fin_in       = fin_ff;
      rshort_in    = rshort_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rshort_in    = short_ff;
         if (short_ff) begin
            lo_in   = '0;
            hi_in   = '0;
            rpos_in = '0;
            fin_in  = 1'b1;
         end else begin
            lo_in   = mac_lo;
            hi_in   = mac_hi;
            rpos_in = pos_ff[cuwf_pkg::POS_W-1:0];
            fin_in  = last_ff && last_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cuwf_pkg::ST_IDLE;
         dir_ff       <= 1'b0;
         sel_ff       <= 2'd0;
         cnt_ff       <= '0;
         wp_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_ff       <= dir_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      t_ff      <= t_in;
      row_ff    <= row_in;
      last_ff   <= last_in;
      short_ff  <= short_in;
      nout_ff   <= nout_in;
      o_ff      <= o_in;
      pos_ff    <= pos_in;
      tap_ff    <= tap_in;
      s1_win_ff <= s1_win_in;
      s1_s_ff   <= s1_s_in;
      s1_g_ff   <= s1_g_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      rpos_ff   <= rpos_in;
      fin_ff    <= fin_in;
      rshort_ff <= rshort_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_low   = lo_ff;
   assign rsp_result_high  = hi_ff;
   assign rsp_position     = rpos_ff;
   assign rsp_final_result = fin_ff;
   assign rsp_short_row    = rshort_ff;

   // a short row word always closes the row
   a_short_final : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rshort_ff) |-> (fin_ff && (lo_ff == '0)))
      else $error("short row word without final flag");

   // no tap left in flight once the block takes new words
   a_idle_drained : assert property (@(posedge clock) disable iff (reset)
      (state_ff == cuwf_pkg::ST_IDLE) |-> (!s1_valid_ff && !mac_busy))
      else $error("tap pipeline busy while idle");

   // tap index stays inside the filter
   a_tap_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == cuwf_pkg::ST_RUN) |-> (tap_ff < t_ff))
      else $error("tap index past filter length");

endmodule

`default_nettype wire

### sim/circular_undecimated_wavelet_filter_top_tb.sv
// ----------------------------------------------------------------------------
// circular_undecimated_wavelet_filter_top_tb
// self-checking bench: a directed table of rows, then random rows over all
// wavelets and both directions, every result checked against a typed word or a
// predictor of the circular filter bank, with random idling on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module circular_undecimated_wavelet_filter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cuwf_pkg::*;

   localparam int TAPS_MAX = 10;
   localparam int HEAD_N   = TAPS_MAX - 1;
   localparam int ROW_LIM  = 4096;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd2;
   localparam longint SAT_HI = 131071;
   localparam longint SAT_LO = -131072;

   typedef struct {
      logic signed [RES_W-1:0] lo;
      logic signed [RES_W-1:0] hi;
      logic [POS_W-1:0]        pos;
      logic                    fin;
      logic                    sr;
   } band_word_t;

   // one directed row: setting, input word, and a typed result where obvious
   typedef struct {
      bit         dir;
      bit [1:0]   wav;
      int         a;
      int         b;
      bit         re;
      bit         typed;
      band_word_t want;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready, req_row_end;
   logic signed [FIELD_W-1:0] req_sample_a, req_sample_b;
   logic rsp_valid, rsp_ready;
   logic signed [RES_W-1:0] rsp_result_low, rsp_result_high;
   logic [POS_W-1:0] rsp_position;
   logic rsp_final_result, rsp_short_row;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   circular_undecimated_wavelet_filter_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_a(req_sample_a), .req_sample_b(req_sample_b),
      .req_row_end(req_row_end),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_low(rsp_result_low), .rsp_result_high(rsp_result_high),
      .rsp_position(rsp_position), .rsp_final_result(rsp_final_result),
      .rsp_short_row(rsp_short_row),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // predictor state: own copy of window, row head, count and registers
   longint     win_a [TAPS_MAX];
   longint     win_b [TAPS_MAX];
   longint     head_a [HEAD_N];
   longint     head_b [HEAD_N];
   int         row_count;
   bit         cfg_dir;
   bit [1:0]   cfg_wav;

   band_word_t pending_bands [$];   // results still owed by the block
   band_word_t fresh_bands [$];     // results of the word just predicted
   bit         failed = 1'b0;
   bit         calm = 1'b0;         // no idling in the last part of the run
   int         words_seen = 0;

   function automatic longint scale_coef(int t, int m);
      return longint'(SCALE_ROM[(t - 4) / 2][m % 10]);
   endfunction

   // wavelet filter is the reversed scaling filter with odd taps negated
   function automatic longint wave_coef(int t, int m);
      longint v;
      v = scale_coef(t, t - 1 - m);
      return (m % 2 == 1) ? -v : v;
   endfunction

   function automatic longint round_clip(longint v, int sh);
      longint r;
      r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
      if (r > SAT_HI) r = SAT_HI;
      if (r < SAT_LO) r = SAT_LO;
      return r;
   endfunction

   // sample pair at row index idx: recent ones from the window, old ones from the head
   function automatic void pair_at(int idx, int len, output longint a, output longint b);
      int d;
      d = len - 1 - idx;
      if (d < TAPS_MAX) begin
         a = win_a[d];
         b = win_b[d];
      end else begin
         a = head_a[idx % HEAD_N];
         b = head_b[idx % HEAD_N];
      end
   endfunction

   function automatic band_word_t split_at(int p, int len, int t, bit fin);
      band_word_t w;
      longint al, ah, a, b;
      int k;
      al = 0;
      ah = 0;
      for (int m = 0; m < t; m++) begin
         k = p + m;
         if (k >= len) k -= len;
         pair_at(k, len, a, b);
         al += a * scale_coef(t, m);
         ah += a * wave_coef(t, m);
      end
      w.lo  = RES_W'(round_clip(al, 15));
      w.hi  = RES_W'(round_clip(ah, 15));
      w.pos = p[POS_W-1:0];
      w.fin = fin;
      w.sr  = 1'b0;
      return w;
   endfunction

   function automatic band_word_t merge_at(int n, int len, int t, bit fin);
      band_word_t w;
      longint acc, a, b;
      int i;
      acc = 0;
      for (int j = 0; j < t; j++) begin
         i = n - j;
         if (i < 0) i += len;
         pair_at(i, len, a, b);
         acc += a * scale_coef(t, j) + b * wave_coef(t, j);
      end
      w.lo  = RES_W'(round_clip(acc, 16));
      w.hi  = '0;
      w.pos = n[POS_W-1:0];
      w.fin = fin;
      w.sr  = 1'b0;
      return w;
   endfunction

   // advance the predictor by one accepted word, results go to fresh_bands
   function automatic void predict_bands(logic signed [FIELD_W-1:0] a,
                                         logic signed [FIELD_W-1:0] b, bit re);
      int t, n, len;
      bit last;
      band_word_t w;
      t = 4 + 2 * cfg_wav;
      n = row_count;
      len = n + 1;
      last = re || (n >= ROW_LIM - 1);
      fresh_bands.delete();
      for (int i = TAPS_MAX - 1; i > 0; i--) begin
         win_a[i] = win_a[i - 1];
         win_b[i] = win_b[i - 1];
      end
      win_a[0] = longint'(a);
      win_b[0] = longint'(b);
      if (n < HEAD_N) begin
         head_a[n] = longint'(a);
         head_b[n] = longint'(b);
      end
      row_count = last ? 0 : len;
      if (len < t) begin
         if (last) begin
            w = '{lo: '0, hi: '0, pos: '0, fin: 1'b1, sr: 1'b1};
            fresh_bands.push_back(w);
         end
         return;
      end
      if (!cfg_dir) begin
         fresh_bands.push_back(split_at(len - t, len, t, last && t == 1));
         if (last) begin
            for (int p = len - t + 1; p < len; p++)
               fresh_bands.push_back(split_at(p, len, t, p == len - 1));
         end
      end else begin
         fresh_bands.push_back(merge_at(n, len, t, 1'b0));
         if (last) begin
            for (int q = 0; q + 1 < t; q++)
               fresh_bands.push_back(merge_at(q, len, t, q + 2 == t));
         end
      end
   endfunction

   // offer one word, hold it until taken, then maybe idle a burst
   task automatic send_word(int a, int b, bit re, bit typed, band_word_t want);
      req_valid    <= 1'b1;
      req_sample_a <= a[FIELD_W-1:0];
      req_sample_b <= b[FIELD_W-1:0];
      req_row_end  <= re;
      do @(posedge clock); while (!req_ready);
      predict_bands(a[FIELD_W-1:0], b[FIELD_W-1:0], re);
      if (typed) pending_bands.push_back(want);
      else foreach (fresh_bands[i]) pending_bands.push_back(fresh_bands[i]);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // register writes only once the block has drained
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      req_valid <= 1'b0;
      while (pending_bands.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_DIRECTION) cfg_dir = value[0];
      else if (idx == CSR_WAVELET) cfg_wav = value[1:0];
      if (idx == CSR_DIRECTION || idx == CSR_WAVELET) row_count = 0;
   endtask

   task automatic set_mode(bit dir, bit [1:0] wav);
      if (dir != cfg_dir) write_reg(CSR_DIRECTION, dir);
      if (wav != cfg_wav) write_reg(CSR_WAVELET, wav);
   endtask

   function automatic int pick_sample();
      case ($urandom_range(0, 7))
         0: return 32767;
         1: return -32768;
         2: return int'($urandom_range(0, 15)) - 8;
         default: return int'($urandom());
      endcase
   endfunction

   // result side: check every taken word, idle in bursts, one long hold-off
   int  hold_left = 0;
   bit  held_once = 1'b0;
   always @(posedge clock) begin
      band_word_t w;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (pending_bands.size() == 0) begin
            $error("unexpected result word at position %0d", rsp_position);
            failed = 1'b1;
         end else begin
            w = pending_bands.pop_front();
            if (rsp_result_low !== w.lo) begin
               $error("result_low expected %0d got %0d", w.lo, rsp_result_low);
               failed = 1'b1;
            end
            if (rsp_result_high !== w.hi) begin
               $error("result_high expected %0d got %0d", w.hi, rsp_result_high);
               failed = 1'b1;
            end
            if (rsp_position !== w.pos) begin
               $error("position expected %0d got %0d", w.pos, rsp_position);
               failed = 1'b1;
            end
            if (rsp_final_result !== w.fin) begin
               $error("final_result expected %0d got %0d", w.fin, rsp_final_result);
               failed = 1'b1;
            end
            if (rsp_short_row !== w.sr) begin
               $error("short_row expected %0d got %0d", w.sr, rsp_short_row);
               failed = 1'b1;
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!held_once && words_seen >= 60) begin
         // long hold-off so the block backs up and stalls its input
         held_once = 1'b1;
         hold_left = 400;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         hold_left = int'($urandom_range(1, 9)) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // directed rows: short rows, extremes, both directions, full wrap at db5
   band_word_t short_word = '{lo: '0, hi: '0, pos: '0, fin: 1'b1, sr: 1'b1};
   band_word_t none_word  = '{lo: '0, hi: '0, pos: '0, fin: 1'b0, sr: 1'b0};
   dir_row_t dir_rows [$];

   initial begin
      bit [1:0] wav_list [4];
      bit       dir_list [4];
      int       sent, len, t;
      bit       d;
      bit [1:0] wv;

      wav_list = '{2'd0, 2'd3, 2'd3, 2'd0};
      dir_list = '{1'b0, 1'b1, 1'b0, 1'b1};
      req_valid    <= 1'b0;
      req_sample_a <= '0;
      req_sample_b <= '0;
      req_row_end  <= 1'b0;
      csr_we       <= 1'b0;
      csr_index    <= '0;
      csr_data     <= '0;
      reset        <= 1'b1;
      cfg_dir = 1'b0;
      cfg_wav = 2'd0;
      row_count = 0;
      foreach (win_a[i]) begin
         win_a[i] = 0;
         win_b[i] = 0;
      end
      foreach (head_a[i]) begin
         head_a[i] = 0;
         head_b[i] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-word row right after reset is a short row
      dir_rows.push_back('{0, 0, 32767, 0, 1, 1, short_word});
      dir_rows.push_back('{0, 0, -32768, 32767, 0, 0, none_word});
      dir_rows.push_back('{0, 0, 32767, -32768, 0, 0, none_word});
      dir_rows.push_back('{0, 0, -32768, 0, 0, 0, none_word});
      dir_rows.push_back('{0, 0, 32767, 0, 1, 0, none_word});
      dir_rows.push_back('{1, 0, 32767, 32767, 0, 0, none_word});
      dir_rows.push_back('{1, 0, -32768, -32768, 0, 0, none_word});
      dir_rows.push_back('{1, 0, 32767, -32768, 0, 0, none_word});
      dir_rows.push_back('{1, 0, -32768, 32767, 1, 0, none_word});
      dir_rows.push_back('{1, 1, 100, -100, 0, 0, none_word});
      dir_rows.push_back('{1, 1, 5, 5, 0, 0, none_word});
      dir_rows.push_back('{1, 1, -1, -1, 1, 1, short_word});
      for (int i = 0; i < 10; i++)
         dir_rows.push_back('{0, 3, (i % 2) ? -32768 : 32767, i, i == 9, 0, none_word});

      foreach (dir_rows[i]) begin
         set_mode(dir_rows[i].dir, dir_rows[i].wav);
         send_word(dir_rows[i].a, dir_rows[i].b, dir_rows[i].re,
                   dir_rows[i].typed, dir_rows[i].want);
      end
      // index with no register behind it
      write_reg(CSR_SPARE, 3);

      // random rows, settings cycle through the extremes first
      sent = 0;
      for (int ph = 0; sent < 150; ph++) begin
         if (ph < 4) begin
            d  = dir_list[ph];
            wv = wav_list[ph];
         end else begin
            d  = 1'($urandom_range(0, 1));
            wv = 2'($urandom_range(0, 3));
         end
         if (sent > 120) calm = 1'b1;
         set_mode(d, wv);
         t = 4 + 2 * wv;
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 4) == 0) len = int'($urandom_range(1, t - 1));
            else len = int'($urandom_range(t, 24));
            for (int i = 0; i < len; i++) begin
               send_word(pick_sample(), pick_sample(), i == len - 1, 1'b0, none_word);
               sent++;
            end
         end
      end
      req_valid <= 1'b0;

      while (pending_bands.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (!failed) $display("[circular_undecimated_wavelet_filter_top] OK");
      else $display("[circular_undecimated_wavelet_filter_top] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("[circular_undecimated_wavelet_filter_top] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
